// File: rtl/neighbor_table_gradient_core_assert.svh
// assertion macros used by the checker file
`ifndef NEIGHBOR_TABLE_GRADIENT_CORE_ASSERT_SVH
`define NEIGHBOR_TABLE_GRADIENT_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define NTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must also hold while reset is applied
`define NTG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ntg_pkg.sv
// shared types and constants for the neighbor table gradient core
`timescale 1ns / 1ps
package ntg_pkg;

    localparam int MAX_NEIGHBORS_DEF = 4;

    localparam int ID_W   = 16;
    localparam int RD_W   = 16;
    localparam int GR_W   = 8;
    localparam int TS_W   = 32;
    localparam int OG_W   = 9;
    localparam int NC_W   = 3;
    localparam int AGE_W  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd64;
    localparam logic [GR_W-1:0]  GRAD_START    = 8'd255;

    // register index as decoded from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_MAX_AGE = 1'b0;

    typedef enum logic [1:0] {
        REQ_RECEIVE = 2'd0,
        REQ_TX_DONE = 2'd1,
        REQ_BUILD   = 2'd2,
        REQ_LOAD    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX_RD,
        S_RX_CHK,
        S_PG_RD,
        S_PG_CHK,
        S_PG_MOVE,
        S_SC_INIT,
        S_SC_RD,
        S_SC_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic signed [RD_W-1:0] reading;
        logic [GR_W-1:0]        gradient;
        logic [TS_W-1:0]        ts;
    } entry_t;

endpackage

// File: rtl/neighbor_table_gradient_core.sv
// neighbor table with hop-count gradient, driven by a small sequencer
//
// input channel: one beat per request (req_type, now_ticks, neighbor fields,
// sample_reading), taken when in_valid is high and in_stall is low. in_stall
// stays high while a request is being worked on; one request at a time.
// output channel: one beat per request (adv_reading, adv_gradient,
// own_gradient_now, neighbor_count) held in an output register until taken.
// a new request is taken while the previous result still waits there.
// every entry visit is a read of the table memory with registered read
// data followed by a compare step, so the work per request grows with
// the number of entries held. the next request can be taken in the cycle
// after its result is loaded.
// max_age is written over the apb port at byte address 0, pready always high.
// reset empties the table (count zero), clears own reading and gradient and
// sets max_age to 64; no clearing pass is needed.
// if the receiver stalls, the result holds and the next request waits in
// its final step until the output register frees.
`timescale 1ns / 1ps
module neighbor_table_gradient_core #(
    parameter int MAX_NEIGHBORS = ntg_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [ntg_pkg::TS_W-1:0]           now_ticks,
    input  logic [ntg_pkg::ID_W-1:0]           neighbor_id,
    input  logic signed [ntg_pkg::RD_W-1:0]    neighbor_reading,
    input  logic [ntg_pkg::GR_W-1:0]           neighbor_gradient,
    input  logic signed [ntg_pkg::RD_W-1:0]    sample_reading,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ntg_pkg::RD_W-1:0]    adv_reading,
    output logic [ntg_pkg::GR_W-1:0]           adv_gradient,
    output logic [ntg_pkg::OG_W-1:0]           own_gradient_now,
    output logic [ntg_pkg::NC_W-1:0]           neighbor_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ntg_pkg::ADDR_W-1:0]         paddr,
    input  logic [ntg_pkg::DATA_W-1:0]         pwdata,
    output logic [ntg_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import ntg_pkg::*;

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    // table memory
    entry_t mem [MAX_NEIGHBORS];
    entry_t rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;

    // control state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [RD_W-1:0]  own_reading_reg, own_reading_next;
    logic [OG_W-1:0]         own_gradient_reg, own_gradient_next;
    logic signed [RD_W-1:0]  best_reg, best_next;
    logic                    any_hi_reg, any_hi_next;
    logic [GR_W-1:0]         min_reg, min_next;
    logic [AGE_W-1:0]        max_age_reg, max_age_next;
    logic                    out_valid_reg, out_valid_next;

    // captured request and output payload
    req_t                    typ_reg;
    logic [TS_W-1:0]         now_reg;
    logic [ID_W-1:0]         nid_reg;
    logic signed [RD_W-1:0]  nrd_reg;
    logic [GR_W-1:0]         ngr_reg;
    logic signed [RD_W-1:0]  adv_reading_reg, adv_reading_next;
    logic [OG_W-1:0]         og_out_reg, og_out_next;
    logic [NC_W-1:0]         nc_out_reg, nc_out_next;

    logic              in_accept;
    logic              out_load;
    logic              cfg_write;
    logic [CNT_W-1:0]  km1;
    logic [CNT_W-1:0]  last;
    logic [TS_W-1:0]   age;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign km1       = idx_reg - CNT_W'(1);
    assign last      = count_reg - CNT_W'(1);
    assign age       = now_reg - rd_data_reg.ts;
    assign cfg_write = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_MAX_AGE)
                    ? {{(DATA_W-AGE_W){1'b0}}, max_age_reg} : '0;

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        own_reading_next  = own_reading_reg;
        own_gradient_next = own_gradient_reg;
        best_next         = best_reg;
        any_hi_next       = any_hi_reg;
        min_next          = min_reg;
        max_age_next      = max_age_reg;
        out_valid_next    = out_valid_reg;
        adv_reading_next  = adv_reading_reg;
        og_out_next       = og_out_reg;
        nc_out_next       = nc_out_reg;
        out_load          = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = idx_reg[IDX_W-1:0];
        wr_data           = '{id: nid_reg, reading: nrd_reg, gradient: ngr_reg, ts: now_reg};
        rd_addr           = idx_reg[IDX_W-1:0];

        if (cfg_write && (paddr[ADDR_W-1:2] == REG_MAX_AGE))
        begin
            max_age_next = pwdata[AGE_W-1:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_t'(req_type))
                        REQ_RECEIVE:
                        begin
                            idx_next   = '0;
                            state_next = S_RX_RD;
                        end
                        REQ_TX_DONE:
                        begin
                            idx_next   = count_reg;
                            state_next = S_PG_RD;
                        end
                        REQ_BUILD:
                        begin
                            if (own_gradient_reg != '0)
                            begin
                                own_reading_next = sample_reading;
                            end
                            state_next = S_SC_INIT;
                        end
                        REQ_LOAD:
                        begin
                            own_reading_next = sample_reading;
                            state_next       = S_SC_INIT;
                        end
                        default:
                        begin
                            state_next = S_SC_INIT;
                        end
                    endcase
                end
            end
            S_RX_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // unknown id: append, or drop when full
                    if (count_reg < CNT_W'(MAX_NEIGHBORS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_SC_INIT;
                end
                else
                begin
                    state_next = S_RX_CHK;
                end
            end
            S_RX_CHK:
            begin
                if (rd_data_reg.id == nid_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_SC_INIT;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RX_RD;
                end
            end
            S_PG_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_SC_INIT;
                end
                else
                begin
                    rd_addr    = km1[IDX_W-1:0];
                    state_next = S_PG_CHK;
                end
            end
            S_PG_CHK:
            begin
                if (age > {{(TS_W-AGE_W){1'b0}}, max_age_reg})
                begin
                    rd_addr    = last[IDX_W-1:0];
                    state_next = S_PG_MOVE;
                end
                else
                begin
                    idx_next   = km1;
                    state_next = S_PG_RD;
                end
            end
            S_PG_MOVE:
            begin
                // last entry fills the gap
                wr_en      = 1'b1;
                wr_addr    = km1[IDX_W-1:0];
                wr_data    = rd_data_reg;
                count_next = last;
                idx_next   = km1;
                state_next = S_PG_RD;
            end
            S_SC_INIT:
            begin
                idx_next    = '0;
                best_next   = own_reading_reg;
                any_hi_next = 1'b0;
                min_next    = GRAD_START;
                state_next  = S_SC_RD;
            end
            S_SC_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (typ_reg == REQ_TX_DONE)
                    begin
                        own_gradient_next = any_hi_reg
                                            ? ({1'b0, min_reg} + OG_W'(1)) : '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SC_CHK;
                end
            end
            S_SC_CHK:
            begin
                if (rd_data_reg.reading > best_reg)
                begin
                    best_next   = rd_data_reg.reading;
                    any_hi_next = 1'b1;
                end
                if (rd_data_reg.gradient < min_reg)
                begin
                    min_next = rd_data_reg.gradient;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SC_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load         = 1'b1;
                    adv_reading_next = best_reg;
                    og_out_next      = own_gradient_reg;
                    nc_out_next      = NC_W'(count_reg);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            count_reg        <= '0;
            own_reading_reg  <= '0;
            own_gradient_reg <= '0;
            best_reg         <= '0;
            any_hi_reg       <= 1'b0;
            min_reg          <= GRAD_START;
            max_age_reg      <= MAX_AGE_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            own_reading_reg  <= own_reading_next;
            own_gradient_reg <= own_gradient_next;
            best_reg         <= best_next;
            any_hi_reg       <= any_hi_next;
            min_reg          <= min_next;
            max_age_reg      <= max_age_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        if (in_accept)
        begin
            typ_reg <= req_t'(req_type);
            now_reg <= now_ticks;
            nid_reg <= neighbor_id;
            nrd_reg <= neighbor_reading;
            ngr_reg <= neighbor_gradient;
        end
        if (out_load)
        begin
            adv_reading_reg <= adv_reading_next;
            og_out_reg      <= og_out_next;
            nc_out_reg      <= nc_out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign adv_reading      = adv_reading_reg;
    assign adv_gradient     = og_out_reg[GR_W-1:0];
    assign own_gradient_now = og_out_reg;
    assign neighbor_count   = nc_out_reg;

endmodule

// File: rtl/ntg_checker.sv
// port-level checker for the neighbor table gradient core, with its bind
`timescale 1ns / 1ps
`include "neighbor_table_gradient_core_assert.svh"
module ntg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] adv_reading,
    input logic [7:0]         adv_gradient,
    input logic [8:0]         own_gradient_now
);

    `NTG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
    `NTG_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(adv_reading) && $stable(adv_gradient) && $stable(own_gradient_now), "stalled result beat changed")
    `NTG_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second request taken while busy")
    `NTG_ASSERT(a_grad_byte, out_valid |-> adv_gradient == own_gradient_now[7:0], "gradient byte does not match own gradient")
    `NTG_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid && !in_stall, "not idle in reset")

endmodule

bind neighbor_table_gradient_core ntg_checker u_ntg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .adv_reading      (adv_reading),
    .adv_gradient     (adv_gradient),
    .own_gradient_now (own_gradient_now)
);
